// ===== hw/rtl/asp_pkg.sv =====
// ----------------------------------------------------------------------------
// asp_pkg
// Shared types and constants of the ANSI SGR stream parser: parse modes,
// character codes, result item layout and register map.
// ----------------------------------------------------------------------------
package asp_pkg;

    // Parse mode of the escape sequence tracker
    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_CSI  = 2'd2
    } mode_t;

    // Character codes
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LBRK  = 8'h5B;   // '['
    localparam logic [7:0] CH_SEMI  = 8'h3B;   // ';'
    localparam logic [7:0] CH_M     = 8'h6D;   // 'm'
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;

    // SGR field codes
    localparam logic [6:0] SGR_RESET    = 7'd0;
    localparam logic [6:0] SGR_BOLD     = 7'd1;
    localparam logic [6:0] SGR_FG_LO    = 7'd30;
    localparam logic [6:0] SGR_FG_HI    = 7'd37;
    localparam logic [6:0] SGR_FG_BR_LO = 7'd90;
    localparam logic [6:0] SGR_FG_BR_HI = 7'd97;
    localparam logic [6:0] FIELD_MAX    = 7'd127;

    // Result kinds
    localparam logic KIND_PRINT  = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    // Register map (index of each register)
    localparam logic REG_DEFAULT_FG = 1'b0;
    localparam logic [3:0] DEFAULT_FG_RESET = 4'd7;

    // One result item
    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
        logic [3:0] fg_color;
        logic       bold;
    } result_t;

    // Handoff from parser core to output stage
    typedef struct packed {
        logic    push;
        result_t res;
    } core_out_t;

endpackage

// ===== hw/rtl/asp_cfg.sv =====
// ----------------------------------------------------------------------------
// asp_cfg
// APB-style register file holding the default foreground color.
// ----------------------------------------------------------------------------
module asp_cfg
    import asp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [3:0]  default_fg
);

    logic [3:0] default_fg_reg;
    logic [3:0] default_fg_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Register write decode
    always_comb begin
        default_fg_next = default_fg_reg;
        if (wr_en && (paddr[2] == REG_DEFAULT_FG)) begin
            default_fg_next = pwdata[3:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_fg_reg <= DEFAULT_FG_RESET;
        end else begin
            default_fg_reg <= default_fg_next;
        end
    end

    // Read back
    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_DEFAULT_FG) begin
            prdata = {28'd0, default_fg_reg};
        end
    end

    assign default_fg = default_fg_reg;

endmodule

// ===== hw/rtl/asp_core.sv =====
// ----------------------------------------------------------------------------
// asp_core
// Escape sequence tracker and SGR field decoder. Updates the parse and
// format state on each accepted item and forms the result item, if any.
// ----------------------------------------------------------------------------
module asp_core
    import asp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] byte_in,
    input  logic [3:0] default_fg,
    output core_out_t  core_out
);

    mode_t      mode_reg, mode_next;
    logic [3:0] cur_fg_reg, cur_fg_next;
    logic       cur_bold_reg, cur_bold_next;
    logic [6:0] field_value_reg, field_value_next;
    logic       field_invalid_reg, field_invalid_next;
    logic       pend_reset_reg, pend_reset_next;
    logic       pend_bold_reg, pend_bold_next;
    logic       pend_cval_reg, pend_cval_next;
    logic [3:0] pend_color_reg, pend_color_next;

    // Field finish results
    logic [6:0]  fv;
    logic        fin_reset, fin_bold, fin_cval;
    logic [3:0]  fin_color;
    logic [10:0] acc_full;
    logic        is_letter, is_digit;

    assign is_letter = ((byte_in >= CH_UC_A) && (byte_in <= CH_UC_Z)) ||
                       ((byte_in >= CH_LC_A) && (byte_in <= CH_LC_Z));
    assign is_digit  = (byte_in >= CH_0) && (byte_in <= CH_9);

    // Digit accumulation, saturating
    assign acc_full = 11'(field_value_reg) * 11'd10 + 11'(byte_in - CH_0);

    // Decode of the field that ends on this byte
    always_comb begin
        fv        = field_invalid_reg ? SGR_RESET : field_value_reg;
        fin_reset = pend_reset_reg;
        fin_bold  = pend_bold_reg;
        fin_cval  = pend_cval_reg;
        fin_color = pend_color_reg;
        if (fv == SGR_RESET) begin
            fin_reset = 1'b1;
            fin_bold  = 1'b0;
            fin_cval  = 1'b0;
            fin_color = 4'd0;
        end else if (fv == SGR_BOLD) begin
            fin_bold = 1'b1;
        end else if ((fv >= SGR_FG_LO) && (fv <= SGR_FG_HI)) begin
            fin_color = {1'b0, 3'(fv - SGR_FG_LO)};
            fin_cval  = 1'b1;
        end else if ((fv >= SGR_FG_BR_LO) && (fv <= SGR_FG_BR_HI)) begin
            fin_color = {1'b1, 3'(fv - SGR_FG_BR_LO)};
            fin_cval  = 1'b1;
        end
    end

    // Next state
    always_comb begin
        mode_next          = mode_reg;
        cur_fg_next        = cur_fg_reg;
        cur_bold_next      = cur_bold_reg;
        field_value_next   = field_value_reg;
        field_invalid_next = field_invalid_reg;
        pend_reset_next    = pend_reset_reg;
        pend_bold_next     = pend_bold_reg;
        pend_cval_next     = pend_cval_reg;
        pend_color_next    = pend_color_reg;

        if (accept) begin
            if ((mode_reg == MODE_CSI)) begin
                if (is_letter) begin
                    if (byte_in == CH_M) begin
                        if (fin_reset) begin
                            cur_fg_next   = default_fg;
                            cur_bold_next = 1'b0;
                        end
                        if (fin_bold) begin
                            cur_bold_next = 1'b1;
                        end
                        if (fin_cval) begin
                            cur_fg_next = fin_color;
                        end
                    end
                    mode_next          = MODE_TEXT;
                    field_value_next   = 7'd0;
                    field_invalid_next = 1'b0;
                    pend_reset_next    = 1'b0;
                    pend_bold_next     = 1'b0;
                    pend_cval_next     = 1'b0;
                    pend_color_next    = 4'd0;
                end else if (byte_in == CH_SEMI) begin
                    field_value_next   = 7'd0;
                    field_invalid_next = 1'b0;
                    pend_reset_next    = fin_reset;
                    pend_bold_next     = fin_bold;
                    pend_cval_next     = fin_cval;
                    pend_color_next    = fin_color;
                end else if (is_digit) begin
                    field_value_next = (acc_full > 11'(FIELD_MAX)) ? FIELD_MAX
                                                                   : acc_full[6:0];
                end else begin
                    field_invalid_next = 1'b1;
                end
            end else if ((mode_reg == MODE_ESC) && (byte_in == CH_LBRK)) begin
                // ESC [ opens a control sequence
                mode_next          = MODE_CSI;
                field_value_next   = 7'd0;
                field_invalid_next = 1'b0;
                pend_reset_next    = 1'b0;
                pend_bold_next     = 1'b0;
                pend_cval_next     = 1'b0;
                pend_color_next    = 4'd0;
            end else begin
                // Text handling; a lone ESC is dropped and the byte falls here
                mode_next = MODE_TEXT;
                if (byte_in == CH_ESC) begin
                    mode_next = MODE_ESC;
                end
            end
        end
    end

    // Result item
    always_comb begin
        core_out.push          = 1'b0;
        core_out.res.kind      = KIND_PRINT;
        core_out.res.char_code = byte_in;
        core_out.res.fg_color  = cur_fg_reg;
        core_out.res.bold      = cur_bold_reg;
        if (accept && (mode_reg != MODE_CSI) &&
            !((mode_reg == MODE_ESC) && (byte_in == CH_LBRK))) begin
            if (byte_in == CH_BS) begin
                core_out.push          = 1'b1;
                core_out.res.kind      = KIND_DELETE;
                core_out.res.char_code = 8'd0;
                core_out.res.fg_color  = 4'd0;
                core_out.res.bold      = 1'b0;
            end else if ((byte_in != CH_ESC) && (byte_in != CH_CR)) begin
                core_out.push = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= MODE_TEXT;
            cur_fg_reg        <= DEFAULT_FG_RESET;
            cur_bold_reg      <= 1'b0;
            field_value_reg   <= 7'd0;
            field_invalid_reg <= 1'b0;
            pend_reset_reg    <= 1'b0;
            pend_bold_reg     <= 1'b0;
            pend_cval_reg     <= 1'b0;
            pend_color_reg    <= 4'd0;
        end else begin
            mode_reg          <= mode_next;
            cur_fg_reg        <= cur_fg_next;
            cur_bold_reg      <= cur_bold_next;
            field_value_reg   <= field_value_next;
            field_invalid_reg <= field_invalid_next;
            pend_reset_reg    <= pend_reset_next;
            pend_bold_reg     <= pend_bold_next;
            pend_cval_reg     <= pend_cval_next;
            pend_color_reg    <= pend_color_next;
        end
    end

    // A result never comes out of sequence bytes
    a_no_push_in_csi: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_CSI) |-> !core_out.push)
        else $error("result produced inside control sequence");

    // ESC in text mode always arms the escape tracker
    a_esc_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (mode_reg == MODE_TEXT) && (byte_in == CH_ESC))
        |=> (mode_reg == MODE_ESC))
        else $error("ESC did not enter escape mode");

    // Format state only moves on a final 'm'
    a_fmt_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(accept && (mode_reg == MODE_CSI) && (byte_in == CH_M))
        |=> ($stable(cur_fg_reg) && $stable(cur_bold_reg)))
        else $error("format changed outside SGR end");

endmodule

// ===== hw/rtl/asp_out.sv =====
// ----------------------------------------------------------------------------
// asp_out
// Result register with one skid entry; decouples input ready from the
// output side's tready.
// ----------------------------------------------------------------------------
module asp_out
    import asp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  core_out_t core_out,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output result_t   out_res
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop      = main_valid_reg && out_ready;
    assign in_ready = !skid_valid_reg;

    // Fill and drain of the two entries
    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || pop) begin
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                main_next       = core_out.res;
                main_valid_next = core_out.push;
            end
        end else if (core_out.push) begin
            skid_next       = core_out.res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

    // Skid entry is only used behind a full result register
    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry valid with empty result register");

    // No push may arrive while the skid entry is occupied
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> !core_out.push)
        else $error("result pushed into full output stage");

endmodule

// ===== hw/rtl/ansi_sgr_stream_parser_unit.sv =====
// Result items are registered in the result register, else in the skid entry.
// Throughput: one byte per cycle while s_tready is high; the parse and SGR
// decode is a single combinational step between the state registers and the
// result register. A one-entry skid stage keeps s_tready independent of m_tready.
// Reset (aresetn low, synchronous): text mode, color 7, bold off, output empty.
// ----------------------------------------------------------------------------
// ansi_sgr_stream_parser_unit
// Terminal byte stream parser: tracks ESC / CSI sequences, applies SGR
// color and bold fields, emits printable bytes and delete items.
// ----------------------------------------------------------------------------
module ansi_sgr_stream_parser_unit
    import asp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] byte_in
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] char_code, [11:8] fg_color, [12] bold
    output logic        m_tuser,    // [0] kind
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       accept;
    logic [3:0] default_fg;
    core_out_t  core_out;
    result_t    out_res;

    assign accept = s_tvalid && s_tready;

    asp_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .default_fg (default_fg)
    );

    asp_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .byte_in    (s_tdata),
        .default_fg (default_fg),
        .core_out   (core_out)
    );

    asp_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .core_out  (core_out),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Pack result item
    assign m_tdata = {3'd0, out_res.bold, out_res.fg_color, out_res.char_code};
    assign m_tuser = out_res.kind;

endmodule
